[src/hpf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpf_pkg: shared types and constants of the Hammer projection core
// Angle formats, CORDIC constants, rounding helpers and register indexes.
// ----------------------------------------------------------------------------
package hpf_pkg;

	localparam int CORDIC_STEPS_DEF = 28;

	// angle to the sine/cosine unit: degrees * 2^17
	localparam int ANG_W  = 27;
	// Q30 trig values and CORDIC datapath
	localparam int TRIG_W = 34;
	// products of two Q30 values, rounded back to Q30
	localparam int MUL_W  = 36;
	// numerators of the two divisions
	localparam int NUM_W  = 64;
	// divisor width
	localparam int DEN_W  = 34;
	// square root: operand and root widths
	localparam int RAD_W  = 62;
	localparam int ROOT_W = 31;
	// quotient bits before saturation
	localparam int QUO_W  = 31;

	localparam logic signed [26:0] LON_HALF_TURN = 27'sd11796480;
	localparam logic signed [26:0] LON_FULL_TURN = 27'sd23592960;
	localparam logic signed [24:0] LAT_QUARTER   = 25'sd5898240;

	localparam logic signed [ANG_W-1:0] A17_90  = 27'sd11796480;
	localparam logic signed [ANG_W-1:0] A17_180 = 27'sd23592960;
	localparam logic signed [ANG_W-1:0] A17_360 = 27'sd47185920;

	localparam logic [37:0] DEG2RAD_Q43 = 38'd153520784549;
	localparam logic signed [TRIG_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
	localparam logic signed [31:0] SQRT2_Q30 = 32'sd1518500250;

	localparam logic [QUO_W-1:0] X_LIMIT = 31'd759250125;
	localparam logic [QUO_W-1:0] Y_LIMIT = 31'd379625063;

	localparam logic [23:0] LON_LIMIT_RST = 24'd11796479;
	localparam logic [22:0] LAT_LIMIT_RST = 23'd5898239;

	typedef enum logic [0:0] {
		CFG_LON_LIMIT = 1'b0,
		CFG_LAT_LIMIT = 1'b1
	} cfg_reg_t;

	// arctangent table in Q30, rounded down
	function automatic logic signed [TRIG_W-1:0] atan_q30(input int i);
		logic signed [TRIG_W-1:0] r;
		begin
			unique case (i)
				0: r = 34'sd843314856;
				1: r = 34'sd497837829;
				2: r = 34'sd263043836;
				3: r = 34'sd133525158;
				4: r = 34'sd67021686;
				5: r = 34'sd33543515;
				6: r = 34'sd16775850;
				7: r = 34'sd8388437;
				8: r = 34'sd4194282;
				9: r = 34'sd2097149;
				default: begin
					if (i < 30)
						r = (34'sd1 <<< (30 - i)) - 34'sd1;
					else
						r = '0;
				end
			endcase
			return r;
		end
	endfunction

	// Q30 times Q30, rounded as floor(p + 2^29) >> 30
	function automatic logic signed [MUL_W-1:0] mul_q30(
		input logic signed [TRIG_W-1:0] a,
		input logic signed [TRIG_W-1:0] b
	);
		logic signed [2*TRIG_W-1:0] p;
		begin
			p = a * b + (68'sd1 <<< 29);
			return p[MUL_W+29:30];
		end
	endfunction

endpackage

[src/hpf_cordic.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpf_cordic: pipelined sine and cosine unit
// Folds the angle into [-90,90] degrees, converts to radians and rotates.
// ----------------------------------------------------------------------------
module hpf_cordic #(
	parameter int STEPS = hpf_pkg::CORDIC_STEPS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  logic signed [hpf_pkg::ANG_W-1:0] angle,
	output logic out_valid,
	output logic signed [hpf_pkg::TRIG_W-1:0] cos_o,
	output logic signed [hpf_pkg::TRIG_W-1:0] sin_o
);

	localparam int AW = hpf_pkg::ANG_W;
	localparam int TW = hpf_pkg::TRIG_W;
	localparam logic [18:0] D_LO = hpf_pkg::DEG2RAD_Q43[18:0];
	localparam logic [18:0] D_HI = hpf_pkg::DEG2RAD_Q43[37:19];

	// wrap and fold
	logic signed [AW-1:0] a_w, a_f, a_n;
	logic fold_neg;

	always_comb begin
		if (angle > hpf_pkg::A17_180)
			a_w = angle - hpf_pkg::A17_360;
		else if (angle <= -hpf_pkg::A17_180)
			a_w = angle + hpf_pkg::A17_360;
		else
			a_w = angle;
		fold_neg = 1'b1;
		if (a_w > hpf_pkg::A17_90)
			a_f = a_w - hpf_pkg::A17_180;
		else if (a_w < -hpf_pkg::A17_90)
			a_f = a_w + hpf_pkg::A17_180;
		else begin
			a_f = a_w;
			fold_neg = 1'b0;
		end
		a_n = -a_f;
	end

	logic v_s1, v_s2, v_s3;
	logic neg_s1, neg_s2, neg_s3;
	logic zneg_s1, zneg_s2;
	logic [23:0] mag_s1;
	logic [42:0] pp_lo_s2, pp_hi_s2;
	logic signed [TW-1:0] z_s3;

	logic [61:0] rad_sum;
	logic [31:0] rad_mag;

	always_comb begin
		rad_sum = {pp_hi_s2, 19'd0} + {19'd0, pp_lo_s2} + (62'd1 << 29);
		rad_mag = rad_sum[61:30];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1  <= fold_neg;
			zneg_s1 <= a_f[AW-1];
			mag_s1  <= a_f[AW-1] ? a_n[23:0] : a_f[23:0];
			neg_s2   <= neg_s1;
			zneg_s2  <= zneg_s1;
			pp_lo_s2 <= mag_s1 * D_LO;
			pp_hi_s2 <= mag_s1 * D_HI;
			neg_s3 <= neg_s2;
			z_s3   <= zneg_s2 ? -$signed({2'b00, rad_mag}) : $signed({2'b00, rad_mag});
		end
	end

	// rotation stages, one iteration each
	logic signed [TW-1:0] x_sn [0:STEPS];
	logic signed [TW-1:0] y_sn [0:STEPS];
	logic signed [TW-1:0] z_sn [0:STEPS];
	logic v_sn [0:STEPS];
	logic neg_sn [0:STEPS];

	assign x_sn[0]   = hpf_pkg::CORDIC_GAIN_Q30;
	assign y_sn[0]   = '0;
	assign z_sn[0]   = z_s3;
	assign v_sn[0]   = v_s3;
	assign neg_sn[0] = neg_s3;

	for (genvar i = 0; i < STEPS; i++) begin : g_rot
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_sn[i+1] <= 1'b0;
			else if (en)
				v_sn[i+1] <= v_sn[i];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				neg_sn[i+1] <= neg_sn[i];
				if (!z_sn[i][TW-1]) begin
					x_sn[i+1] <= x_sn[i] - (y_sn[i] >>> i);
					y_sn[i+1] <= y_sn[i] + (x_sn[i] >>> i);
					z_sn[i+1] <= z_sn[i] - hpf_pkg::atan_q30(i);
				end else begin
					x_sn[i+1] <= x_sn[i] + (y_sn[i] >>> i);
					y_sn[i+1] <= y_sn[i] - (x_sn[i] >>> i);
					z_sn[i+1] <= z_sn[i] + hpf_pkg::atan_q30(i);
				end
			end
		end
	end

	// undo the fold
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (en)
			out_valid <= v_sn[STEPS];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cos_o <= neg_sn[STEPS] ? -x_sn[STEPS] : x_sn[STEPS];
			sin_o <= neg_sn[STEPS] ? -y_sn[STEPS] : y_sn[STEPS];
		end
	end

endmodule

[src/hpf_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpf_div: pipelined saturating signed divider
// One quotient bit per stage; quotients past LIM or a zero divisor saturate, a zero numerator gives zero.
// ----------------------------------------------------------------------------
module hpf_div #(
	parameter int QW = hpf_pkg::QUO_W,
	parameter int OW = 31,
	parameter logic [QW-1:0] LIM = QW'(hpf_pkg::X_LIMIT)
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  logic signed [hpf_pkg::NUM_W-1:0] num,
	input  logic [hpf_pkg::DEN_W-1:0] den,
	output logic out_valid,
	output logic signed [OW-1:0] quo
);

	localparam int NW = hpf_pkg::NUM_W;
	localparam int DW = hpf_pkg::DEN_W;

	logic [NW-1:0] mag;
	logic [NW-1:0] den_x;

	always_comb begin
		mag   = num[NW-1] ? -num : num;
		den_x = {{(NW-DW){1'b0}}, den};
	end

	logic v_sn [0:QW];
	logic neg_sn [0:QW];
	logic zero_sn [0:QW];
	logic ovf_sn [0:QW];
	logic [NW-1:0] rem_sn [0:QW];
	logic [NW-1:0] den_sn [0:QW];
	logic [QW-1:0] q_sn [0:QW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_sn[0] <= 1'b0;
		else if (en)
			v_sn[0] <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_sn[0]  <= num[NW-1];
			zero_sn[0] <= (num == '0);
			ovf_sn[0]  <= (mag >> QW) >= den_x;
			rem_sn[0]  <= mag;
			den_sn[0]  <= den_x;
			q_sn[0]    <= '0;
		end
	end

	for (genvar j = 0; j < QW; j++) begin : g_bit
		localparam int K = QW - 1 - j;
		logic take;
		assign take = !ovf_sn[j] && ((rem_sn[j] >> K) >= den_sn[j]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_sn[j+1] <= 1'b0;
			else if (en)
				v_sn[j+1] <= v_sn[j];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				neg_sn[j+1]  <= neg_sn[j];
				zero_sn[j+1] <= zero_sn[j];
				ovf_sn[j+1]  <= ovf_sn[j];
				den_sn[j+1]  <= den_sn[j];
				rem_sn[j+1]  <= take ? rem_sn[j] - (den_sn[j] << K) : rem_sn[j];
				q_sn[j+1]    <= take ? (q_sn[j] | (QW'(1) << K)) : q_sn[j];
			end
		end
	end

	// clip and restore the sign
	logic [QW-1:0] q_sat;
	logic signed [OW-1:0] q_mag;

	always_comb begin
		q_sat = (ovf_sn[QW] || q_sn[QW] > LIM) ? LIM : q_sn[QW];
		q_mag = $signed({1'b0, q_sat[OW-2:0]});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (en)
			out_valid <= v_sn[QW];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (zero_sn[QW])
				quo <= '0;
			else
				quo <= neg_sn[QW] ? -q_mag : q_mag;
		end
	end

endmodule

[src/hammer_projection_forward_core.sv]
`timescale 1ns / 1ps
// Throughput: one beat per cycle; every stage is a register and the whole pipe
//   advances together, held only while a finished output beat is stalled.
// The CORDIC pipes, the 31-stage square root and the two 33-stage dividers set the depth.
// Reset: asynchronous, active low; clears valid bits and loads the two limit
//   registers with their defaults. Data registers are not reset.
// ----------------------------------------------------------------------------
// hammer_projection_forward_core: Hammer equal-area forward projection
// Clamps longitude and latitude, takes sine and cosine through two CORDIC
// pipes, then forms t = sqrt(1 + cos(lat)cos(lon/2)) and divides.
// ----------------------------------------------------------------------------
module hammer_projection_forward_core #(
	parameter int CORDIC_STEPS = hpf_pkg::CORDIC_STEPS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [0:0] cfg_index,
	input  logic [23:0] cfg_data,
	input  logic in_valid,
	output logic in_stall,
	input  logic signed [25:0] lon_deg,
	input  logic signed [23:0] lat_deg,
	output logic out_valid,
	input  logic out_stall,
	output logic signed [30:0] proj_x,
	output logic signed [29:0] proj_y
);

	localparam int AW = hpf_pkg::ANG_W;
	localparam int TW = hpf_pkg::TRIG_W;
	localparam int MW = hpf_pkg::MUL_W;
	localparam int NW = hpf_pkg::NUM_W;
	localparam int RW = hpf_pkg::RAD_W;
	localparam int TR = hpf_pkg::ROOT_W;

	// Advance everything unless the output beat is waiting on the sink.
	logic en;
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	// Limit registers.
	logic [23:0] lon_limit_q;
	logic [22:0] lat_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lon_limit_q <= hpf_pkg::LON_LIMIT_RST;
			lat_limit_q <= hpf_pkg::LAT_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (hpf_pkg::cfg_reg_t'(cfg_index))
				hpf_pkg::CFG_LON_LIMIT: lon_limit_q <= cfg_data;
				hpf_pkg::CFG_LAT_LIMIT: lat_limit_q <= cfg_data[22:0];
			endcase
		end
	end

	// Stage 1: clamp. Longitude past a half turn wraps once; latitude past a
	// quarter turn passes through untouched.
	logic signed [26:0] lon_x, ll, lon_c;
	logic signed [24:0] lat_x, bl, lat_c;

	always_comb begin
		lon_x = 27'(lon_deg);
		ll    = $signed({3'b000, lon_limit_q});
		lat_x = 25'(lat_deg);
		bl    = $signed({2'b00, lat_limit_q});
		if (lon_x > ll && lon_x <= hpf_pkg::LON_HALF_TURN)
			lon_c = ll;
		else if (lon_x < -ll && lon_x >= -hpf_pkg::LON_HALF_TURN)
			lon_c = -ll;
		else if (lon_x > hpf_pkg::LON_HALF_TURN)
			lon_c = lon_x - hpf_pkg::LON_FULL_TURN;
		else
			lon_c = lon_x;
		if (lat_x > bl && lat_x <= hpf_pkg::LAT_QUARTER)
			lat_c = bl;
		else if (lat_x < -bl && lat_x >= -hpf_pkg::LAT_QUARTER)
			lat_c = -bl;
		else
			lat_c = lat_x;
	end

	logic v_s1;
	logic signed [AW-1:0] lon_a_s1, lat_a_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (en)
			v_s1 <= in_valid;
	end

	// The trig angle is degrees * 2^17: lon/2 is the longitude word itself,
	// lat is the latitude word doubled (sign carried into the top bit).
	always_ff @(posedge clk) begin
		if (en) begin
			lon_a_s1 <= lon_c;
			lat_a_s1 <= {lat_c[24], lat_c, 1'b0};
		end
	end

	// Sine and cosine of both angles in parallel.
	logic lat_cv, lon_cv;
	logic signed [TW-1:0] cl, sl, ch, sh;

	hpf_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_lat (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s1),
		.angle    (lat_a_s1),
		.out_valid(lat_cv),
		.cos_o    (cl),
		.sin_o    (sl)
	);

	hpf_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_lon (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s1),
		.angle    (lon_a_s1),
		.out_valid(lon_cv),
		.cos_o    (ch),
		.sin_o    (sh)
	);

	// Stage 2: the three products.
	logic v_s2;
	logic signed [MW-1:0] mcc_s2, mcs_s2;
	logic signed [NW-1:0] numy_s2;
	logic signed [65:0] ny_w;

	assign ny_w = sl * hpf_pkg::SQRT2_Q30;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (en)
			v_s2 <= lat_cv;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mcc_s2  <= hpf_pkg::mul_q30(cl, ch);
			mcs_s2  <= hpf_pkg::mul_q30(cl, sh);
			numy_s2 <= ny_w[NW-1:0];
		end
	end

	// Stage 3: radicand (zero when 1 + cos*cos is not positive) and x numerator.
	logic v_s3;
	logic [RW-1:0] rad_s3;
	logic signed [NW-1:0] numx_s3, numy_s3;
	logic signed [MW:0] s_sum;
	logic signed [67:0] nx_w;

	always_comb begin
		s_sum = (37'sd1 <<< 30) + 37'(mcc_s2);
		nx_w  = mcs_s2 * hpf_pkg::SQRT2_Q30;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s3 <= 1'b0;
		else if (en)
			v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s3  <= (s_sum > 0) ? {s_sum[31:0], 30'd0} : '0;
			numx_s3 <= nx_w[NW-1:0];
			numy_s3 <= numy_s2;
		end
	end

	// Square root: one root bit per stage, restoring.
	logic v_sq [0:TR];
	logic [RW-1:0] rem_sq [0:TR];
	logic [TR-1:0] root_sq [0:TR];
	logic signed [NW-1:0] nx_sq [0:TR];
	logic signed [NW-1:0] ny_sq [0:TR];

	assign v_sq[0]    = v_s3;
	assign rem_sq[0]  = rad_s3;
	assign root_sq[0] = '0;
	assign nx_sq[0]   = numx_s3;
	assign ny_sq[0]   = numy_s3;

	for (genvar j = 0; j < TR; j++) begin : g_sqrt
		localparam int K = TR - 1 - j;
		logic [63:0] trial;
		logic take;

		always_comb begin
			trial = ({33'd0, root_sq[j]} << (K + 1)) + (64'd1 << (2 * K));
			take  = {2'b00, rem_sq[j]} >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_sq[j+1] <= 1'b0;
			else if (en)
				v_sq[j+1] <= v_sq[j];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_sq[j+1]  <= take ? RW'({2'b00, rem_sq[j]} - trial) : rem_sq[j];
				root_sq[j+1] <= take ? (root_sq[j] | (TR'(1) << K)) : root_sq[j];
				nx_sq[j+1]   <= nx_sq[j];
				ny_sq[j+1]   <= ny_sq[j];
			end
		end
	end

	// Divide: x by 2t, y by 4t.
	logic [hpf_pkg::DEN_W-1:0] den_x, den_y;
	logic dx_v, dy_v;

	assign den_x = {2'b00, root_sq[TR], 1'b0};
	assign den_y = {1'b0, root_sq[TR], 2'b00};

	hpf_div #(.QW(hpf_pkg::QUO_W), .OW(31), .LIM(hpf_pkg::X_LIMIT)) u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_sq[TR]),
		.num      (nx_sq[TR]),
		.den      (den_x),
		.out_valid(dx_v),
		.quo      (proj_x)
	);

	hpf_div #(.QW(hpf_pkg::QUO_W), .OW(30), .LIM(hpf_pkg::Y_LIMIT)) u_div_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_sq[TR]),
		.num      (ny_sq[TR]),
		.den      (den_y),
		.out_valid(dy_v),
		.quo      (proj_y)
	);

	// The divider's final register is the output register.
	assign out_valid = dx_v;

	a_cordic_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		lat_cv == lon_cv)
		else $error("cordic pipes out of step");

	a_div_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		dx_v == dy_v)
		else $error("divider pipes out of step");

	a_x_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (proj_x <= $signed({1'b0, hpf_pkg::X_LIMIT[29:0]}) &&
			proj_x >= -$signed({1'b0, hpf_pkg::X_LIMIT[29:0]})))
		else $error("proj_x beyond its limit");

	a_y_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (proj_y <= $signed({1'b0, hpf_pkg::Y_LIMIT[28:0]}) &&
			proj_y >= -$signed({1'b0, hpf_pkg::Y_LIMIT[28:0]})))
		else $error("proj_y beyond its limit");

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the Hammer forward projection core
// Drives coordinate pairs under random sender gaps and receiver stalls, and
// predicts every output beat with a bit-exact fixed-point projection
// (CORDIC sine/cosine, integer square root, saturating divide). Beats are
// checked in order. The run steps through several limit register settings,
// the extremes among them.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int  PIPE_DEPTH  = 99;
	localparam int  CYCLE_LIMIT = 400000;
	localparam int  RAND_ITEMS  = 1500;

	localparam longint LON_MAX = 23592960;
	localparam longint LAT_MAX = 5898240;
	localparam longint XLIM    = 759250125;
	localparam longint YLIM    = 379625063;
	localparam longint ROOT2   = 1518500250;
	localparam longint GAIN    = 652032874;
	localparam longint unsigned D2R = 64'd153520784549;

	typedef struct {
		logic signed [30:0] x;
		logic signed [29:0] y;
	} proj_t;

	typedef struct {
		longint lon;
		longint lat;
	} pair_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	hpf_pkg::cfg_reg_t cfg_index = hpf_pkg::CFG_LON_LIMIT;
	logic [23:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [25:0] lon_deg = '0;
	logic signed [23:0] lat_deg = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [30:0] proj_x;
	logic signed [29:0] proj_y;

	// shadow copy of the two limit registers
	longint lon_lim = hpf_pkg::LON_LIMIT_RST;
	longint lat_lim = hpf_pkg::LAT_LIMIT_RST;

	proj_t  pending_proj[$];
	int     mismatches = 0;
	int     beats_in = 0;
	int     beats_out = 0;
	int     cycles = 0;
	bit     calm_rx = 1'b0;
	bit     calm_tx = 1'b0;

	hammer_projection_forward_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.lon_deg(lon_deg), .lat_deg(lat_deg),
		.out_valid(out_valid), .out_stall(out_stall),
		.proj_x(proj_x), .proj_y(proj_y)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------- predictor
	function automatic longint q30_mul(longint a, longint b);
		return (a * b + (64'sd1 <<< 29)) >>> 30;
	endfunction

	function automatic longint atan_step(int i);
		longint head[10] = '{843314856, 497837829, 263043836, 133525158, 67021686,
			33543515, 16775850, 8388437, 4194282, 2097149};
		if (i < 10)
			return head[i];
		if (i < 30)
			return (64'sd1 <<< (30 - i)) - 1;
		return 0;
	endfunction

	// angle in degrees * 2^17 -> cosine and sine in Q30
	task automatic sin_cos_q30(input longint ang, output longint c, output longint s);
		bit flip;
		bit zneg;
		longint unsigned mag;
		longint x, y, z, nx;
		flip = 1'b0;
		x = GAIN;
		y = 0;
		// wrap once into (-180,180], then fold into [-90,90]
		if (ang > 64'sd23592960)
			ang -= 64'sd47185920;
		if (ang <= -64'sd23592960)
			ang += 64'sd47185920;
		if (ang > 64'sd11796480) begin
			ang -= 64'sd23592960;
			flip = 1'b1;
		end else if (ang < -64'sd11796480) begin
			ang += 64'sd23592960;
			flip = 1'b1;
		end
		zneg = ang < 0;
		mag = zneg ? -ang : ang;
		mag = (mag * D2R + (64'd1 << 29)) >> 30;
		z = zneg ? -longint'(mag) : longint'(mag);
		for (int i = 0; i < hpf_pkg::CORDIC_STEPS_DEF; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z -= atan_step(i);
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z += atan_step(i);
			end
			x = nx;
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endtask

	function automatic longint unsigned root_floor(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint div_saturate(longint num, longint unsigned den, longint lim);
		longint unsigned q;
		if (num == 0)
			return 0;
		if (den == 0)
			return num > 0 ? lim : -lim;
		q = longint'(num > 0 ? num : -num) / den;
		if (q > lim)
			q = lim;
		return num > 0 ? longint'(q) : -longint'(q);
	endfunction

	task automatic hammer_project(input longint lon, input longint lat, output proj_t p);
		longint cl, sl, ch, sh, s, xv, yv;
		longint unsigned t;
		if (lon > lon_lim && lon <= 64'sd11796480)
			lon = lon_lim;
		else if (lon < -lon_lim && lon >= -64'sd11796480)
			lon = -lon_lim;
		else if (lon > 64'sd11796480)
			lon -= LON_MAX;
		if (lat > lat_lim && lat <= LAT_MAX)
			lat = lat_lim;
		else if (lat < -lat_lim && lat >= -LAT_MAX)
			lat = -lat_lim;
		sin_cos_q30(lat * 2, cl, sl);
		sin_cos_q30(lon, ch, sh);
		s = (64'sd1 <<< 30) + q30_mul(cl, ch);
		t = s > 0 ? root_floor(longint'(s) << 30) : 0;
		xv = div_saturate(q30_mul(cl, sh) * ROOT2, 2 * t, XLIM);
		yv = div_saturate(sl * ROOT2, 4 * t, YLIM);
		p.x = xv[30:0];
		p.y = yv[29:0];
	endtask

	// ----------------------------------------------------------------- checking
	task automatic report_mismatch(string field, longint want, longint got);
		mismatches++;
		$display("MISMATCH beat %0d %s: expected %0d, got %0d", beats_out, field, want, got);
	endtask

	int stall_left = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_proj.size() == 0) begin
					report_mismatch("unexpected beat", 0, 0);
				end else begin
					proj_t want;
					want = pending_proj.pop_front();
					if (proj_x !== want.x)
						report_mismatch("proj_x", want.x, proj_x);
					if (proj_y !== want.y)
						report_mismatch("proj_y", want.y, proj_y);
				end
				beats_out++;
				// draw the stall for the next beat
				stall_left = calm_rx ? 0 : $urandom_range(0, 9);
			end else if (stall_left > 0) begin
				stall_left--;
			end
			out_stall <= (stall_left != 0);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d beats outstanding", cycles,
				pending_proj.size());
			$display("hammer_projection_forward_core test failed");
			$finish;
		end
	end

	// ----------------------------------------------------------------- stimulus
	task automatic write_limit(hpf_pkg::cfg_reg_t idx, longint val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[23:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == hpf_pkg::CFG_LON_LIMIT)
			lon_lim = val & 64'hFF_FFFF;
		else
			lat_lim = val & 64'h7F_FFFF;
	endtask

	// wait out the pipe so the limits can change safely
	task automatic drain();
		while (pending_proj.size() != 0)
			@(posedge clk);
	endtask

	// drive one beat; valid stays high across back-to-back beats
	task automatic send_pair(longint lon, longint lat);
		int gap;
		proj_t p;
		gap = calm_tx ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		lon_deg <= lon[25:0];
		lat_deg <= lat[23:0];
		do @(posedge clk); while (in_stall);
		hammer_project(lon, lat, p);
		pending_proj.insert(pending_proj.size(), p);
		beats_in++;
	endtask

	function automatic longint pick_lon();
		int sel;
		sel = $urandom_range(0, 9);
		case (sel)
			0: return $urandom_range(0, 40) - 20 + 11796480;
			1: return -($urandom_range(0, 40) - 20 + 11796480);
			2: return lon_lim + $urandom_range(0, 6) - 3;
			3: return -(lon_lim + $urandom_range(0, 6) - 3);
			4: return $urandom_range(0, 2) == 0 ? LON_MAX : -LON_MAX;
			default: return longint'($urandom_range(0, 2 * LON_MAX)) - LON_MAX;
		endcase
	endfunction

	function automatic longint pick_lat();
		int sel;
		longint v;
		sel = $urandom_range(0, 9);
		case (sel)
			0: v = lat_lim + $urandom_range(0, 6) - 3;
			1: v = -(lat_lim + $urandom_range(0, 6) - 3);
			2: v = $urandom_range(0, 1) ? LAT_MAX : -LAT_MAX;
			default: v = longint'($urandom_range(0, 2 * LAT_MAX)) - LAT_MAX;
		endcase
		if (v > LAT_MAX)
			v = LAT_MAX;
		if (v < -LAT_MAX)
			v = -LAT_MAX;
		return v;
	endfunction

	pair_t directed[] = '{
		'{0, 0}, '{1, 1}, '{-1, -1},
		'{LON_MAX, LAT_MAX}, '{-LON_MAX, -LAT_MAX},
		// exactly a half turn, and one step past it either way
		'{11796480, 0}, '{-11796480, 0}, '{11796481, 100}, '{-11796481, -100},
		// poles and the limits themselves
		'{0, LAT_MAX}, '{0, -LAT_MAX}, '{11796479, 5898239}, '{-11796479, -5898239},
		// corner of the map: a half turn of longitude at either pole
		'{11796480, LAT_MAX}, '{-11796480, -LAT_MAX},
		'{23592959, 1}, '{-23592959, -1}, '{5898240, 2949120}, '{-5898240, -2949120}
	};

	typedef struct {
		longint lon_l;
		longint lat_l;
	} limits_t;

	initial begin
		limits_t phases[5];
		phases[0] = '{11796480, 5898240};
		phases[1] = '{0, 0};
		phases[2] = '{1, 1};
		phases[3] = '{0, 0};
		phases[4] = '{11796479, 5898239};
		phases[3].lon_l = $urandom_range(1, 11796479);
		phases[3].lat_l = $urandom_range(1, 5898239);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows at reset limits; the first eight again at both extremes
		foreach (directed[i])
			send_pair(directed[i].lon, directed[i].lat);
		in_valid <= 1'b0;
		drain();

		// random part: one phase per limit setting
		foreach (phases[ph]) begin
			write_limit(hpf_pkg::CFG_LON_LIMIT, phases[ph].lon_l);
			write_limit(hpf_pkg::CFG_LAT_LIMIT, phases[ph].lat_l);
			for (int n = 0; n < RAND_ITEMS / 5; n++) begin
				// alternate stretches of full pressure and random idling
				if (n % 60 == 0) begin
					calm_tx = ($urandom_range(0, 3) == 0);
					calm_rx = ($urandom_range(0, 3) == 0);
				end
				if (ph == 2 && n == 150) begin
					in_valid <= 1'b0;
					drain();
				end
				if (n < 8 && ph < 2)
					send_pair(directed[n].lon, directed[n].lat);
				else
					send_pair(pick_lon(), pick_lat());
			end
			in_valid <= 1'b0;
			drain();
		end

		drain();
		repeat (PIPE_DEPTH + 20) @(posedge clk);
		$display("covered %0d beats in, %0d beats out over five limit settings", beats_in,
			beats_out);
		$display("mismatches: %0d, beats left unmatched: %0d", mismatches,
			pending_proj.size());
		if (mismatches == 0 && pending_proj.size() == 0) begin
			$display("hammer_projection_forward_core test passed");
		end else begin
			$display("hammer_projection_forward_core test failed");
		end
		$finish;
	end

endmodule

[sim.f]
src/hpf_pkg.sv
src/hpf_cordic.sv
src/hpf_div.sv
src/hammer_projection_forward_core.sv
tb/tb_top.sv
